### design/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int HEAP_GRANULES = 1024;
    localparam int GRANULE_BYTES = 8;

    localparam int ADDR_W     = 13;                    // payload byte address
    localparam int HDR_W      = 14;                    // header / byte position
    localparam int IDX_W      = $clog2(HEAP_GRANULES); // header store index
    localparam int GRAN_SHIFT = $clog2(GRANULE_BYTES);

    localparam logic [HDR_W-1:0] HEAP_BYTES = HDR_W'(HEAP_GRANULES * GRANULE_BYTES);
    localparam logic [HDR_W-1:0] GRAN_B     = HDR_W'(GRANULE_BYTES);
    localparam logic [HDR_W-1:0] ROUND_ADD  = HDR_W'(2 * GRANULE_BYTES - 1);
    localparam logic [HDR_W-1:0] GRAN_MASK  = ~(HDR_W'(GRANULE_BYTES - 1));

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_REALLOC = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] block_address;
        logic [ADDR_W-1:0] request_bytes;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] payload_address;
        logic              success;
    } t_rsp;

endpackage

### design/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/first_fit_heap_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit allocator over an implicit free list of block headers.
// ----------------------------------------------------------------------------
// One request is handled at a time; o_in_ready is high only while the
// sequencer is idle. Headers live in a 1024 x 14 RAM (one entry per 8-byte
// granule, block size in bytes with bit 0 as the allocated bit); the break
// pointer is a register cleared by reset. The RAM needs no clearing pass, so
// the block is ready right after reset. Timing is set by the single RAM read
// port: every header visited costs a read step and a check step. A free
// passes dispatch, a re-read and a write of the header; a realloc that keeps
// its block reads and checks the old header; a free of a non-block address,
// an unused op or an oversized request goes from dispatch straight to the
// result. An allocate walks the headers, then writes the split remainder if
// any and the allocated header, or grows the break. A growing realloc adds
// the old-header lookup and, once the allocate succeeds, a free of the old
// block. After the result is loaded the sequencer is idle again. The result
// sits in an output register, so a new request may be taken while the
// previous result still waits for its transfer; the sequencer only stalls at
// its final step if that register is still full.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ffha_pkg::t_req  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output ffha_pkg::t_rsp  o_out_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_WALK_RD,     // present header address at current position
        S_WALK_CHK,    // header data back: fit, skip, or give up
        S_SPLIT_WR,    // remainder header
        S_FIT_WR,      // allocated header of the chosen block
        S_EXTEND,      // grow the break
        S_OLD_RD,      // realloc: fetch header of the old block
        S_OLD_CHK,
        S_FREE_RD,
        S_FREE_WR,
        S_DONE
    } t_state;

    t_state r_state;

    logic [1:0]                   r_op;
    logic [ffha_pkg::ADDR_W-1:0]  r_addr;
    logic [ffha_pkg::HDR_W-1:0]   r_blk;       // rounded block size in bytes
    logic                         r_vblk;      // address names a block below break
    logic [ffha_pkg::IDX_W-1:0]   r_old_idx;   // header index of the given block
    logic                         r_free_old;  // realloc moved: free old after alloc
    logic [ffha_pkg::HDR_W-1:0]   r_pos;       // walk position in bytes
    logic [ffha_pkg::HDR_W-1:0]   r_sz;        // size of the block that fits
    logic [ffha_pkg::HDR_W-1:0]   r_brk;       // heap break in bytes
    logic [ffha_pkg::ADDR_W-1:0]  r_res_addr;
    logic                         r_res_ok;
    logic                         r_out_valid;
    ffha_pkg::t_rsp               r_out_data;

    // RAM port
    logic                         ram_we;
    logic [ffha_pkg::IDX_W-1:0]   ram_waddr;
    logic [ffha_pkg::HDR_W-1:0]   ram_wdata;
    logic [ffha_pkg::IDX_W-1:0]   ram_raddr;
    logic [ffha_pkg::HDR_W-1:0]   ram_rdata;

    // Request decode
    logic [ffha_pkg::HDR_W-1:0]   in_need;
    logic [ffha_pkg::HDR_W-1:0]   in_blk;
    logic [ffha_pkg::HDR_W-1:0]   in_addr_ext;
    logic [ffha_pkg::HDR_W-1:0]   in_hdr_pos;   // header byte position of the block

    // Walk / check
    logic [ffha_pkg::HDR_W-1:0]   rd_size;
    logic [ffha_pkg::HDR_W-1:0]   split_pos;
    logic                         out_free;

    assign in_need     = (i_in_data.request_bytes == '0)
                         ? ffha_pkg::HDR_W'(1)
                         : ffha_pkg::HDR_W'(i_in_data.request_bytes);
    assign in_blk      = (in_need + ffha_pkg::ROUND_ADD) & ffha_pkg::GRAN_MASK;
    assign in_addr_ext = ffha_pkg::HDR_W'(i_in_data.block_address);
    assign in_hdr_pos  = in_addr_ext - ffha_pkg::GRAN_B;

    assign rd_size     = {ram_rdata[ffha_pkg::HDR_W-1:1], 1'b0};
    assign split_pos   = r_pos + r_blk;
    assign out_free    = !r_out_valid || i_out_ready;

    // RAM addressing per sequencer step
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_old_idx;
        ram_wdata = '0;
        ram_raddr = r_old_idx;
        case (r_state)
            S_WALK_RD: begin
                ram_raddr = r_pos[ffha_pkg::GRAN_SHIFT +: ffha_pkg::IDX_W];
            end
            S_SPLIT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = split_pos[ffha_pkg::GRAN_SHIFT +: ffha_pkg::IDX_W];
                ram_wdata = r_sz - r_blk;
            end
            S_FIT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos[ffha_pkg::GRAN_SHIFT +: ffha_pkg::IDX_W];
                ram_wdata = r_blk | ffha_pkg::HDR_W'(1);
            end
            S_EXTEND: begin
                ram_we    = (r_blk <= ffha_pkg::HEAP_BYTES - r_brk);
                ram_waddr = r_brk[ffha_pkg::GRAN_SHIFT +: ffha_pkg::IDX_W];
                ram_wdata = r_blk | ffha_pkg::HDR_W'(1);
            end
            S_FREE_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_old_idx;
                ram_wdata = rd_size;
            end
            default: begin
            end
        endcase
    end

    ffha_ram #(
        .WIDTH (ffha_pkg::HDR_W),
        .DEPTH (ffha_pkg::HEAP_GRANULES)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_brk       <= '0;
            r_out_valid <= 1'b0;
            r_free_old  <= 1'b0;
        end else begin
            // S_DONE reloads the register itself
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op       <= i_in_data.op;
                        r_addr     <= i_in_data.block_address;
                        r_blk      <= in_blk;
                        r_vblk     <= (in_addr_ext >= ffha_pkg::GRAN_B)
                                   && (i_in_data.block_address[ffha_pkg::GRAN_SHIFT-1:0] == '0)
                                   && (in_hdr_pos < r_brk);
                        r_old_idx  <= in_hdr_pos[ffha_pkg::GRAN_SHIFT +: ffha_pkg::IDX_W];
                        r_free_old <= 1'b0;
                        r_state    <= S_DISPATCH;
                    end
                end

                S_DISPATCH: begin
                    r_res_addr <= '0;
                    r_res_ok   <= 1'b0;
                    r_pos      <= '0;
                    case (r_op)
                        ffha_pkg::OP_ALLOC: begin
                            r_state <= (r_blk > ffha_pkg::HEAP_BYTES) ? S_DONE : S_WALK_RD;
                        end
                        ffha_pkg::OP_FREE: begin
                            if (r_vblk) begin
                                r_state <= S_FREE_RD;
                            end else begin
                                r_res_ok <= 1'b1;
                                r_state  <= S_DONE;
                            end
                        end
                        ffha_pkg::OP_REALLOC: begin
                            if (r_vblk) begin
                                r_state <= S_OLD_RD;
                            end else begin
                                r_state <= (r_blk > ffha_pkg::HEAP_BYTES) ? S_DONE : S_WALK_RD;
                            end
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end

                S_WALK_RD: begin
                    r_state <= (r_pos < r_brk) ? S_WALK_CHK : S_EXTEND;
                end

                S_WALK_CHK: begin
                    // zero size or a block past the break: chain is broken
                    if (rd_size == '0 || rd_size > r_brk - r_pos) begin
                        r_state <= S_EXTEND;
                    end else if (!ram_rdata[0] && rd_size >= r_blk) begin
                        r_sz    <= rd_size;
                        r_state <= (rd_size > r_blk) ? S_SPLIT_WR : S_FIT_WR;
                    end else begin
                        r_pos   <= r_pos + rd_size;
                        r_state <= S_WALK_RD;
                    end
                end

                S_SPLIT_WR: begin
                    r_state <= S_FIT_WR;
                end

                S_FIT_WR: begin
                    r_res_addr <= ffha_pkg::ADDR_W'(r_pos + ffha_pkg::GRAN_B);
                    r_res_ok   <= 1'b1;
                    r_state    <= r_free_old ? S_FREE_RD : S_DONE;
                end

                S_EXTEND: begin
                    if (r_blk > ffha_pkg::HEAP_BYTES - r_brk) begin
                        r_state <= S_DONE;
                    end else begin
                        r_res_addr <= ffha_pkg::ADDR_W'(r_brk + ffha_pkg::GRAN_B);
                        r_res_ok   <= 1'b1;
                        r_brk      <= r_brk + r_blk;
                        r_state    <= r_free_old ? S_FREE_RD : S_DONE;
                    end
                end

                S_OLD_RD: begin
                    r_state <= S_OLD_CHK;
                end

                S_OLD_CHK: begin
                    if (r_blk <= rd_size) begin
                        r_res_addr <= r_addr;
                        r_res_ok   <= 1'b1;
                        r_state    <= S_DONE;
                    end else begin
                        r_free_old <= 1'b1;
                        r_state    <= (r_blk > ffha_pkg::HEAP_BYTES) ? S_DONE : S_WALK_RD;
                    end
                end

                S_FREE_RD: begin
                    // re-read: the alloc may have rewritten this entry
                    r_state <= S_FREE_WR;
                end

                S_FREE_WR: begin
                    if (!r_free_old) begin
                        r_res_addr <= '0;
                        r_res_ok   <= 1'b1;
                    end
                    r_state <= S_DONE;
                end

                S_DONE: begin
                    if (out_free) begin
                        r_out_data.payload_address <= r_res_ok ? r_res_addr : '0;
                        r_out_data.success         <= r_res_ok;
                        r_out_valid                <= 1'b1;
                        r_state                    <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### design/ffha_checker.sv
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffha_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input ffha_pkg::t_req i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input ffha_pkg::t_rsp o_out_data
);

    // a pending result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    // one request in flight: ready drops after an input transfer
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while a request is in progress");

    // failure never carries an address
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.success |-> o_out_data.payload_address == '0)
        else $error("failed result with nonzero address");

    // returned nonzero payload addresses are granule aligned
    a_addr_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.payload_address != '0 |->
            o_out_data.payload_address[ffha_pkg::GRAN_SHIFT-1:0] == '0)
        else $error("misaligned payload address");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("not idle after reset");

endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

### verif/ffha_sb_pkg.sv
// ----------------------------------------------------------------------------
// ffha_sb_pkg
// Scoreboard for the first-fit heap allocator: tracks the heap layout and
// queues the result predicted for every request transfer.
// ----------------------------------------------------------------------------
package ffha_sb_pkg;

    timeunit 1ns;
    timeprecision 1ps;

    import ffha_pkg::*;

    localparam int unsigned HEAP_SIZE = HEAP_GRANULES * GRANULE_BYTES;
    localparam int unsigned GRAN      = GRANULE_BYTES;

    class alloc_scoreboard;
        logic [HDR_W-1:0] hdr [HEAP_GRANULES];
        bit               hdr_written [HEAP_GRANULES];
        int unsigned      brk;
        t_rsp             pending [$];
        int unsigned      n_checked;
        int unsigned      n_errors;

        function new();
            foreach (hdr[i]) begin
                hdr[i]         = '0;
                hdr_written[i] = 1'b0;
            end
            brk       = 0;
            n_checked = 0;
            n_errors  = 0;
        endfunction

        // header plus payload, rounded up to whole granules; zero counts as one
        function int unsigned block_span(int unsigned req);
            int unsigned need;
            need = (req == 0) ? 1 : req;
            return ((need + 2 * GRAN - 1) / GRAN) * GRAN;
        endfunction

        function bit is_block(int unsigned a);
            return (a >= GRAN) && (a % GRAN == 0) && (a - GRAN < brk);
        endfunction

        function void write_hdr(int unsigned idx, int unsigned val);
            hdr[idx]         = HDR_W'(val);
            hdr_written[idx] = 1'b1;
        endfunction

        function int unsigned hdr_size(int unsigned idx);
            return {hdr[idx][HDR_W-1:1], 1'b0};
        endfunction

        // Free/realloc must never point at a header that was never written;
        // such an address is knocked off alignment so it reads as no block.
        function logic [ADDR_W-1:0] legal_address(logic [1:0] op, logic [ADDR_W-1:0] a);
            if ((op == OP_FREE || op == OP_REALLOC) && is_block(a)
                && !hdr_written[(a - GRAN) / GRAN])
                return a | ADDR_W'(1);
            return a;
        endfunction

        function bit first_fit(int unsigned req, output int unsigned addr);
            int unsigned blk;
            int unsigned pos;
            int unsigned sz;
            blk  = block_span(req);
            pos  = 0;
            addr = 0;
            if (blk > HEAP_SIZE)
                return 1'b0;
            while (pos < brk) begin
                sz = hdr_size(pos / GRAN);
                if (sz == 0 || sz > brk - pos)
                    break;
                if (!hdr[pos / GRAN][0] && sz >= blk) begin
                    if (sz > blk)
                        write_hdr((pos + blk) / GRAN, sz - blk);
                    write_hdr(pos / GRAN, blk | 1);
                    addr = pos + GRAN;
                    return 1'b1;
                end
                pos += sz;
            end
            if (blk > HEAP_SIZE - brk)
                return 1'b0;
            write_hdr(brk / GRAN, blk | 1);
            addr = brk + GRAN;
            brk += blk;
            return 1'b1;
        endfunction

        function t_rsp note_request(t_req r);
            int unsigned a;
            int unsigned req;
            int unsigned addr;
            int unsigned idx;
            bit          ok;
            t_rsp        rsp;
            a    = r.block_address;
            req  = r.request_bytes;
            addr = 0;
            ok   = 1'b0;
            idx  = (a >= GRAN) ? (a - GRAN) / GRAN : 0;
            case (r.op)
                OP_ALLOC: begin
                    ok = first_fit(req, addr);
                end
                OP_FREE: begin
                    if (is_block(a))
                        hdr[idx][0] = 1'b0;
                    ok = 1'b1;
                end
                OP_REALLOC: begin
                    if (!is_block(a)) begin
                        ok = first_fit(req, addr);
                    end else if (block_span(req) <= hdr_size(idx)) begin
                        addr = a;
                        ok   = 1'b1;
                    end else begin
                        ok = first_fit(req, addr);
                        if (ok)
                            hdr[idx][0] = 1'b0;
                    end
                end
                default: ok = 1'b0;
            endcase
            rsp.payload_address = ok ? ADDR_W'(addr) : '0;
            rsp.success         = ok;
            pending.push_back(rsp);
            return rsp;
        endfunction

        function void check_response(t_rsp got);
            t_rsp exp;
            if (pending.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result, actual addr=%0d success=%0b",
                         $time, got.payload_address, got.success);
                return;
            end
            exp = pending.pop_front();
            n_checked++;
            if (got.payload_address !== exp.payload_address) begin
                n_errors++;
                $display("%0t: payload_address mismatch, expected %0d actual %0d",
                         $time, exp.payload_address, got.payload_address);
            end
            if (got.success !== exp.success) begin
                n_errors++;
                $display("%0t: success mismatch, expected %0b actual %0b",
                         $time, exp.success, got.success);
            end
        endfunction
    endclass

endpackage

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top-level testbench of the first-fit heap allocator.
// A directed pass covers zero and oversized requests, exact fit, split,
// double free, bad addresses and the unused op; a random pass then runs
// alloc/free/realloc traffic on live blocks with some noise, bursty input
// and a stalling result sink, all checked against a scoreboard.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ffha_pkg::*;
    import ffha_sb_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;   // no operation behind this code

    localparam int RANDOM_ITEMS   = 500;
    localparam int RESET_CYCLES   = 12;
    localparam int DRAIN_CYCLES   = 64;
    // A full walk over ~512 minimal blocks plus the longest sink stall and
    // sender gap stays far below this limit.
    localparam int WATCHDOG_LIMIT = 10000;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_ready = 1'b0;
    t_req i_in_data   = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_rsp o_out_data;

    alloc_scoreboard   sb;
    logic [ADDR_W-1:0] live_blocks [$];     // payload addresses held right now
    int unsigned       op_count [4];
    int unsigned       n_refused;

    first_fit_heap_allocator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_req make_req(logic [1:0] op, int unsigned a, int unsigned bytes);
        t_req r;
        r.op            = op;
        r.block_address = ADDR_W'(a);
        r.request_bytes = ADDR_W'(bytes);
        return r;
    endfunction

    function automatic void drop_live(logic [ADDR_W-1:0] a);
        for (int i = 0; i < live_blocks.size(); i++) begin
            if (live_blocks[i] == a) begin
                live_blocks.delete(i);
                break;
            end
        end
    endfunction

    // Drive one request, hold it until the transfer, then let the
    // scoreboard predict its result from the state it leaves behind.
    task automatic send_request(input t_req r);
        t_rsp exp;
        r.block_address = sb.legal_address(r.op, r.block_address);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (!o_in_ready);
        exp = sb.note_request(r);
        op_count[r.op]++;
        if (!exp.success)
            n_refused++;
        // keep the pool of live blocks in step so later frees hit real blocks
        case (r.op)
            OP_ALLOC: begin
                if (exp.success)
                    live_blocks.push_back(exp.payload_address);
            end
            OP_FREE: begin
                drop_live(r.block_address);
            end
            OP_REALLOC: begin
                if (exp.success && exp.payload_address != r.block_address) begin
                    drop_live(r.block_address);
                    live_blocks.push_back(exp.payload_address);
                end
            end
            default: ;
        endcase
    endtask

    task automatic idle_sender(input int cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Hold off input until every predicted result has been taken.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // Random traffic: mostly small allocs, frees and reallocs of live
    // blocks; a share of fully random requests as noise.
    function automatic t_req pick_request();
        t_req        r;
        int unsigned kind;
        int unsigned size_pick;
        size_pick = $urandom_range(0, 99);
        r.op            = OP_ALLOC;
        r.block_address = ADDR_W'($urandom);
        if (size_pick < 90)
            r.request_bytes = ADDR_W'($urandom_range(0, 96));
        else if (size_pick < 97)
            r.request_bytes = ADDR_W'($urandom_range(97, 1024));
        else
            r.request_bytes = ADDR_W'($urandom_range(1025, 8191));
        kind = $urandom_range(0, 99);
        if (kind >= 85) begin
            r.op            = 2'($urandom);
            r.block_address = ADDR_W'($urandom);
            r.request_bytes = ADDR_W'($urandom);
        end else if (kind < 42 && live_blocks.size() > 0) begin
            r.op            = (kind < 25) ? OP_FREE : OP_REALLOC;
            r.block_address = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
        end
        return r;
    endfunction

    // Result monitor: every transfer on the output goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_response(o_out_data);
    end

    // Result sink: keeps picking at random between always ready, coin
    // flips, and mostly ready with occasional long stalls.
    initial begin : result_sink
        int mode;
        int stall;
        stall = 0;
        forever begin
            mode = $urandom_range(0, 2);
            repeat (64) begin
                @(negedge i_clk);
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    default: begin
                        if (stall > 0) begin
                            stall--;
                            i_out_ready <= 1'b0;
                        end else if ($urandom_range(0, 15) == 0) begin
                            stall = $urandom_range(1, 24);
                            i_out_ready <= 1'b0;
                        end else begin
                            i_out_ready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // Watchdog: ends the run once no transfer happens for too long.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, sb.pending.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        t_req        r;
        int unsigned useful;
        int unsigned burst;
        bit          paused;
        sb        = new();
        n_refused = 0;
        foreach (op_count[i])
            op_count[i] = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed: layout after reset is known, so addresses are fixed
        send_request(make_req(OP_ALLOC, 0, 0));            // zero request -> 8
        send_request(make_req(OP_ALLOC, 0, 8191));         // larger than the heap
        send_request(make_req(OP_ALLOC, 0, 1));            // -> 24
        send_request(make_req(OP_ALLOC, 0, 8));            // -> 40
        send_request(make_req(OP_ALLOC, 0, 9));            // three granules -> 56
        send_request(make_req(OP_ALLOC, 0, 40));           // -> 80, break 120
        send_request(make_req(OP_FREE, 24, 0));
        send_request(make_req(OP_FREE, 24, 0));            // free of a free block
        send_request(make_req(OP_ALLOC, 0, 3));            // exact fit at 24
        send_request(make_req(OP_FREE, 80, 0));
        send_request(make_req(OP_ALLOC, 0, 10));           // split, remainder left
        send_request(make_req(OP_REALLOC, 80, 4));         // shrinks, stays put
        send_request(make_req(OP_REALLOC, 56, 100));       // grows, moves, frees old
        send_request(make_req(OP_REALLOC, 0, 5));          // address below a granule
        send_request(make_req(OP_REALLOC, 61, 5));         // unaligned address
        send_request(make_req(OP_REALLOC, 8184, 2));       // past the break
        send_request(make_req(OP_FREE, 4, 0));
        send_request(make_req(OP_FREE, 8184, 0));
        send_request(make_req(OP_FREE, 8191, 8191));
        send_request(make_req(OP_UNUSED, 8191, 8191));
        send_request(make_req(OP_ALLOC, 0, 8176));         // heap exhausted
        send_request(make_req(OP_REALLOC, 128, 8100));     // failed grow keeps old
        send_request(make_req(OP_ALLOC, 8191, 0));
        wait_drained();

        // ---- random: bursts with gaps, one full drain halfway
        useful = 0;
        paused = 1'b0;
        while (useful < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                r = pick_request();
                r.block_address = sb.legal_address(r.op, r.block_address);
                // ignored requests do not count toward the item budget
                if (r.op != OP_UNUSED && !(r.op == OP_FREE && !sb.is_block(r.block_address)))
                    useful++;
                send_request(r);
            end
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 12));
            if (!paused && useful >= RANDOM_ITEMS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d allocs, %0d frees, %0d reallocs, %0d unused ops;",
                 op_count[OP_ALLOC], op_count[OP_FREE], op_count[OP_REALLOC],
                 op_count[OP_UNUSED]);
        $display("%0d results checked, %0d refused, break ended at %0d bytes.",
                 sb.n_checked, n_refused, sb.brk);
        if (sb.n_errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### first_fit_heap_allocator_top.f
design/ffha_pkg.sv
design/ffha_ram.sv
design/first_fit_heap_allocator_top.sv
design/ffha_checker.sv
verif/ffha_sb_pkg.sv
verif/tb.sv
